// ===== src/cpdt_pkg.sv =====
// cluster pair distance table: shared types and constants
// no dependencies; used by the interfaces and the top level
package cpdt_pkg;

  localparam int unsigned VERTEX_W     = 10;
  localparam int unsigned CLUSTER_W    = 6;
  localparam int unsigned NUM_VERTICES = 1 << VERTEX_W;
  localparam int unsigned PAIR_AW      = 2 * CLUSTER_W;
  localparam int unsigned NUM_PAIRS    = 1 << PAIR_AW;
  localparam int unsigned COST_FIELD_W = 16;
  localparam int unsigned TOTAL_W      = 40;
  localparam int unsigned COUNT_W      = 20;
  localparam int unsigned ND_W         = 8;
  localparam int unsigned DIV_W        = ND_W + COUNT_W;
  localparam int unsigned DIV_STEPS    = TOTAL_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [ND_W-1:0] ND_RESET = ND_W'(1);

  // register index, taken from the word-address bit of paddr
  localparam logic REG_NEIGHBOR_DIST = 1'b0;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_EDGE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_LOOK,
    ST_EDGE_UPD,
    ST_Q_MUL,
    ST_Q_DIV,
    ST_RESULT
  } state_t;

endpackage

// ===== src/cpdt_item_if.sv =====
// input channel of the cluster pair distance table: valid/ready plus item fields
// depends on cpdt_pkg
interface cpdt_item_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         operation;
  logic [cpdt_pkg::VERTEX_W-1:0]      vertex_a;
  logic [cpdt_pkg::VERTEX_W-1:0]      vertex_b;
  logic [cpdt_pkg::COST_FIELD_W-1:0]  edge_cost;
  logic [cpdt_pkg::CLUSTER_W-1:0]     cluster_a;
  logic [cpdt_pkg::CLUSTER_W-1:0]     cluster_b;

  modport source (
    output valid, operation, vertex_a, vertex_b, edge_cost, cluster_a, cluster_b,
    input  ready
  );

  modport sink (
    input  valid, operation, vertex_a, vertex_b, edge_cost, cluster_a, cluster_b,
    output ready
  );
endinterface

// ===== src/cpdt_result_if.sv =====
// result channel of the cluster pair distance table: valid/ready plus result fields
// depends on cpdt_pkg
interface cpdt_result_if;
  logic                               valid;
  logic                               ready;
  logic [cpdt_pkg::COST_FIELD_W-1:0]  min_cost;
  logic [cpdt_pkg::COST_FIELD_W-1:0]  max_cost;
  logic [cpdt_pkg::TOTAL_W-1:0]       radius;
  logic                               is_neighbor;

  modport source (
    output valid, min_cost, max_cost, radius, is_neighbor,
    input  ready
  );

  modport sink (
    input  valid, min_cost, max_cost, radius, is_neighbor,
    output ready
  );
endinterface

// ===== src/cluster_pair_distance_table_top.sv =====
// cluster pair distance table, top level: vertex map, pair min/max table, radius divider
// depends on cpdt_pkg, cpdt_item_if, cpdt_result_if
//
// usage
//   in_item carries one item per beat: set vertex cluster, add edge or query pair.
//   out_result returns exactly one beat per item, in order; only queries carry
//   nonzero fields (min, max, radius, neighbor flag).
//   cfg_* is an apb write/read port holding the radius factor at byte address 0.
// sequence per item (one item in flight at a time)
//   set or unused code: straight to the result state
//   add edge: the vertex map read, then the pair table
//   read-modify-write, each through a synchronous memory
//   query: pair table read, divisor product, then the 40-step radix-2 divider for the radius
// reset
//   after rst_n the pair table is swept to its empty values, one entry a
//   cycle over all 4096 entries; in_item.ready stays low until then. config writes
//   are taken throughout. the vertex map is not cleared.
// stalls
//   the result register frees the engine: a new item is taken while a result
//   waits; an item whose result is ready holds until the register is free.
module cluster_pair_distance_table_top #(
  parameter int unsigned COST_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpdt_item_if.sink                      in_item,
  cpdt_result_if.source                  out_result,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cpdt_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [cpdt_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [cpdt_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  localparam int unsigned CW     = COST_BITS;
  localparam int unsigned CLW    = cpdt_pkg::CLUSTER_W;
  localparam int unsigned PAW    = cpdt_pkg::PAIR_AW;
  localparam int unsigned TW     = cpdt_pkg::TOTAL_W;
  localparam int unsigned NW     = cpdt_pkg::COUNT_W;
  localparam int unsigned DW     = cpdt_pkg::DIV_W;
  localparam int unsigned FW     = cpdt_pkg::COST_FIELD_W;
  localparam int unsigned EXT_W  = 48;

  function automatic logic [PAW-1:0] pair_key(input logic [CLW-1:0] c1,
                                              input logic [CLW-1:0] c2);
    // table is symmetric: keep one entry per unordered pair
    return (c1 < c2) ? {c1, c2} : {c2, c1};
  endfunction

  // memories
  logic [CLW-1:0]  vc_mem [cpdt_pkg::NUM_VERTICES];
  logic [2*CW-1:0] pm_mem [cpdt_pkg::NUM_PAIRS];

  cpdt_pkg::state_t state_r, state_nxt;

  logic             in_fire;
  logic             slot_free;
  logic             load_out;
  logic             vc_we, vc_re;
  logic             pm_we, pm_re;
  logic [PAW-1:0]   pm_waddr, pm_raddr;
  logic [2*CW-1:0]  pm_wdata;
  logic [2*CW-1:0]  pm_rdata_r;
  logic [CLW-1:0]   vc_rd_a_r, vc_rd_b_r;

  logic [PAW-1:0]   clr_idx_r;
  logic [PAW-1:0]   pair_idx_r;
  logic [1:0]       op_r;
  logic [CW-1:0]    cost_r;
  logic [EXT_W-1:0] cost_ext;

  logic [cpdt_pkg::ND_W-1:0] nd_r;
  logic [TW-1:0]    total_r;
  logic [TW:0]      total_sum;
  logic [NW-1:0]    edges_r;

  logic [CW-1:0]    cur_min, cur_max, new_min, new_max;
  logic [CW-1:0]    res_min_r, res_max_r;

  logic [DW-1:0]    div_r;
  logic             dz_r;
  logic [DW-1:0]    rem_r;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_diff;
  logic             rem_ge;
  logic [TW-1:0]    quo_r;
  logic [cpdt_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [TW-1:0]    radius;
  logic [EXT_W-1:0] min_ext, max_ext;

  logic             out_valid_r;
  logic [FW-1:0]    out_min_r, out_max_r;
  logic [TW-1:0]    out_radius_r;
  logic             out_nb_r;

  logic             cfg_wr;

  // handshakes
  assign in_fire   = in_item.valid && in_item.ready;
  assign slot_free = !out_valid_r || out_result.ready;

  // state machine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpdt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_item.ready = 1'b0;
    load_out      = 1'b0;
    unique case (state_r)
      cpdt_pkg::ST_CLEAR: begin
        if (clr_idx_r == '1) state_nxt = cpdt_pkg::ST_IDLE;
      end
      cpdt_pkg::ST_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          unique case (in_item.operation)
            cpdt_pkg::OP_EDGE:  state_nxt = cpdt_pkg::ST_EDGE_LOOK;
            cpdt_pkg::OP_QUERY: state_nxt = cpdt_pkg::ST_Q_MUL;
            default:            state_nxt = cpdt_pkg::ST_RESULT;
          endcase
        end
      end
      cpdt_pkg::ST_EDGE_LOOK: state_nxt = cpdt_pkg::ST_EDGE_UPD;
      cpdt_pkg::ST_EDGE_UPD:  state_nxt = cpdt_pkg::ST_RESULT;
      cpdt_pkg::ST_Q_MUL:     state_nxt = cpdt_pkg::ST_Q_DIV;
      cpdt_pkg::ST_Q_DIV: begin
        if (div_cnt_r == cpdt_pkg::DIV_CNT_W'(cpdt_pkg::DIV_STEPS - 1)) begin
          state_nxt = cpdt_pkg::ST_RESULT;
        end
      end
      cpdt_pkg::ST_RESULT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = cpdt_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // vertex map
  assign vc_we = in_fire && (in_item.operation == cpdt_pkg::OP_SET);
  assign vc_re = in_fire && (in_item.operation == cpdt_pkg::OP_EDGE);

  always_ff @(posedge clk) begin
    if (vc_we) vc_mem[in_item.vertex_a] <= in_item.cluster_a;
    if (vc_re) begin
      vc_rd_a_r <= vc_mem[in_item.vertex_a];
      vc_rd_b_r <= vc_mem[in_item.vertex_b];
    end
  end

  // pair table
  assign cur_min = pm_rdata_r[CW-1:0];
  assign cur_max = pm_rdata_r[2*CW-1:CW];
  assign new_min = (cost_r < cur_min) ? cost_r : cur_min;
  assign new_max = (cost_r > cur_max) ? cost_r : cur_max;

  always_comb begin
    pm_re    = 1'b0;
    pm_raddr = pair_key(in_item.cluster_a, in_item.cluster_b);
    if (state_r == cpdt_pkg::ST_EDGE_LOOK) begin
      pm_re    = 1'b1;
      pm_raddr = pair_key(vc_rd_a_r, vc_rd_b_r);
    end else if (in_fire && (in_item.operation == cpdt_pkg::OP_QUERY)) begin
      pm_re = 1'b1;
    end
  end

  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = pair_idx_r;
    pm_wdata = {new_max, new_min};
    if (state_r == cpdt_pkg::ST_CLEAR) begin
      pm_we    = 1'b1;
      pm_waddr = clr_idx_r;
      pm_wdata = {{CW{1'b0}}, {CW{1'b1}}};
    end else if (state_r == cpdt_pkg::ST_EDGE_UPD) begin
      pm_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    if (pm_re) pm_rdata_r <= pm_mem[pm_raddr];
  end

  // running totals, config and clear sweep
  assign total_sum = (TW+1)'(total_r) + (TW+1)'(cost_r);
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                     (cfg_paddr[cpdt_pkg::APB_AW-1] == cpdt_pkg::REG_NEIGHBOR_DIST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      nd_r      <= cpdt_pkg::ND_RESET;
      total_r   <= '0;
      edges_r   <= '0;
    end else begin
      if (state_r == cpdt_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + PAW'(1);
      if (cfg_wr) nd_r <= cfg_pwdata[cpdt_pkg::ND_W-1:0];
      if (state_r == cpdt_pkg::ST_EDGE_UPD) begin
        total_r <= total_sum[TW] ? '1 : total_sum[TW-1:0];
        if (edges_r != '1) edges_r <= edges_r + NW'(1);
      end
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[cpdt_pkg::APB_AW-1] == cpdt_pkg::REG_NEIGHBOR_DIST) ?
                      cpdt_pkg::APB_DW'(nd_r) : '0;

  // item capture and radius divider
  assign cost_ext = EXT_W'(in_item.edge_cost);
  assign rem_sh   = {rem_r, quo_r[TW-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign rem_ge   = (rem_sh >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_item.operation;
      cost_r <= cost_ext[CW-1:0];
    end
    if (state_r == cpdt_pkg::ST_EDGE_LOOK) pair_idx_r <= pm_raddr;
    unique case (state_r)
      cpdt_pkg::ST_Q_MUL: begin
        res_min_r <= cur_min;
        res_max_r <= cur_max;
        div_r     <= DW'(nd_r) * DW'(edges_r);
        dz_r      <= (nd_r == '0) || (edges_r == '0);
        quo_r     <= total_r;
        rem_r     <= '0;
        div_cnt_r <= '0;
      end
      cpdt_pkg::ST_Q_DIV: begin
        rem_r     <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
        quo_r     <= {quo_r[TW-2:0], rem_ge};
        div_cnt_r <= div_cnt_r + cpdt_pkg::DIV_CNT_W'(1);
      end
      default: ;
    endcase
  end

  // result register
  assign radius  = dz_r ? '0 : quo_r;
  assign min_ext = EXT_W'(res_min_r);
  assign max_ext = EXT_W'(res_max_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_result.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (op_r == cpdt_pkg::OP_QUERY) begin
        out_min_r    <= min_ext[FW-1:0];
        out_max_r    <= max_ext[FW-1:0];
        out_radius_r <= radius;
        out_nb_r     <= (TW'(res_min_r) < radius);
      end else begin
        out_min_r    <= '0;
        out_max_r    <= '0;
        out_radius_r <= '0;
        out_nb_r     <= 1'b0;
      end
    end
  end

  assign out_result.valid       = out_valid_r;
  assign out_result.min_cost    = out_min_r;
  assign out_result.max_cost    = out_max_r;
  assign out_result.radius      = out_radius_r;
  assign out_result.is_neighbor = out_nb_r;

endmodule
